>>> rtl/csl_pkg.sv
package csl_pkg;

  localparam int COEF_WIDTH   = 16;
  localparam int RESULT_WIDTH = 32;
  localparam int FRAC_SHIFT   = 16;

  // 2x2 minor of two rows, product of three entries, and a sum of three such products.
  localparam int MINOR_W = 2 * COEF_WIDTH + 1;
  localparam int PROD_W  = 3 * COEF_WIDTH + 1;
  localparam int DET_W   = 3 * COEF_WIDTH + 3;

  localparam int PIPE_STAGES = 3 + 2 + RESULT_WIDTH + 1;

  localparam logic [1:0] MODE_TWO   = 2'd2;
  localparam logic [1:0] MODE_RESET = 2'd3;

  // Q8.8 value of 1.0, used for the z coefficient of row 3 in two-unknown mode.
  localparam int ONE_Q = 1 << 8;

  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [RESULT_WIDTH-1:0] sol_t;
  typedef logic signed [DET_W-1:0]        det_t;

  typedef struct packed {
    coef_t row1_coef_x;
    coef_t row1_coef_y;
    coef_t row1_coef_z;
    coef_t row1_rhs;
    coef_t row2_coef_x;
    coef_t row2_coef_y;
    coef_t row2_coef_z;
    coef_t row2_rhs;
    coef_t row3_coef_x;
    coef_t row3_coef_y;
    coef_t row3_coef_z;
    coef_t row3_rhs;
  } csl_in_t;

  typedef struct packed {
    sol_t sol_x;
    sol_t sol_y;
    sol_t sol_z;
    logic singular;
  } csl_out_t;

  typedef struct packed {
    det_t d;
    det_t dx;
    det_t dy;
    det_t dz;
  } csl_dets_t;

endpackage

>>> rtl/csl_det.sv
module csl_det (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic              mode_two,
  input  csl_pkg::csl_in_t  in_data,
  output logic              out_valid,
  output csl_pkg::csl_dets_t dets
);

  localparam int CW = csl_pkg::COEF_WIDTH;
  localparam int MW = csl_pkg::MINOR_W;
  localparam int PW = csl_pkg::PROD_W;
  localparam int DW = csl_pkg::DET_W;

  // Columns x, y, z, rhs; rows 1..3 as index 0..2.
  logic signed [CW-1:0] col [4][3];

  always_comb begin
    col[0][0] = in_data.row1_coef_x;
    col[1][0] = in_data.row1_coef_y;
    col[2][0] = in_data.row1_coef_z;
    col[3][0] = in_data.row1_rhs;
    col[0][1] = in_data.row2_coef_x;
    col[1][1] = in_data.row2_coef_y;
    col[2][1] = in_data.row2_coef_z;
    col[3][1] = in_data.row2_rhs;
    col[0][2] = in_data.row3_coef_x;
    col[1][2] = in_data.row3_coef_y;
    col[2][2] = in_data.row3_coef_z;
    col[3][2] = in_data.row3_rhs;
    if (mode_two) begin
      // The two-unknown system sits in the upper left; row 3 becomes z = 0 with a unit z coefficient.
      col[2][0] = '0;
      col[2][1] = '0;
      col[2][2] = CW'(csl_pkg::ONE_Q);
      col[0][2] = '0;
      col[1][2] = '0;
      col[3][2] = '0;
    end
  end

  // Stage A: the six 2x2 minors of rows 1 and 2, plus row 3.
  logic                 a_valid;
  logic signed [MW-1:0] mxy, mxz, mxr, myz, myr, mzr;
  logic signed [CW-1:0] r3 [4];

  function automatic logic signed [MW-1:0] minor2(
    input logic signed [CW-1:0] a0, input logic signed [CW-1:0] a1,
    input logic signed [CW-1:0] b0, input logic signed [CW-1:0] b1
  );
    logic signed [2*CW-1:0] p, q;
    p = a0 * b1;
    q = b0 * a1;
    return MW'(p) - MW'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      mxy <= minor2(col[0][0], col[0][1], col[1][0], col[1][1]);
      mxz <= minor2(col[0][0], col[0][1], col[2][0], col[2][1]);
      mxr <= minor2(col[0][0], col[0][1], col[3][0], col[3][1]);
      myz <= minor2(col[1][0], col[1][1], col[2][0], col[2][1]);
      myr <= minor2(col[1][0], col[1][1], col[3][0], col[3][1]);
      mzr <= minor2(col[2][0], col[2][1], col[3][0], col[3][1]);
      for (int c = 0; c < 4; c++) begin
        r3[c] <= col[c][2];
      end
    end
  end

  // Stage B: row 3 entries times minors, twelve products.
  logic                 b_valid;
  logic signed [PW-1:0] pr [12];

  function automatic logic signed [PW-1:0] mul3(
    input logic signed [CW-1:0] a, input logic signed [MW-1:0] m
  );
    return PW'(a * m);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      // D = x3*myz - y3*mxz + z3*mxy
      pr[0]  <= mul3(r3[0], myz);
      pr[1]  <= mul3(r3[1], mxz);
      pr[2]  <= mul3(r3[2], mxy);
      // Dx = r3*myz + y3*mzr - z3*myr
      pr[3]  <= mul3(r3[3], myz);
      pr[4]  <= mul3(r3[1], mzr);
      pr[5]  <= mul3(r3[2], myr);
      // Dy = -x3*mzr - r3*mxz + z3*mxr
      pr[6]  <= mul3(r3[0], mzr);
      pr[7]  <= mul3(r3[3], mxz);
      pr[8]  <= mul3(r3[2], mxr);
      // Dz = x3*myr - y3*mxr + r3*mxy
      pr[9]  <= mul3(r3[0], myr);
      pr[10] <= mul3(r3[1], mxr);
      pr[11] <= mul3(r3[3], mxy);
    end
  end

  // Stage C: signed sums give the four determinants.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
    if (en) begin
      dets.d  <= DW'(pr[0]) - DW'(pr[1]) + DW'(pr[2]);
      dets.dx <= DW'(pr[3]) + DW'(pr[4]) - DW'(pr[5]);
      dets.dy <= DW'(pr[8]) - DW'(pr[6]) - DW'(pr[7]);
      dets.dz <= DW'(pr[9]) - DW'(pr[10]) + DW'(pr[11]);
    end
  end

endmodule

>>> rtl/csl_div.sv
module csl_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  csl_pkg::det_t       num,
  input  csl_pkg::det_t       den,
  output logic                out_valid,
  output logic                out_zero,
  output csl_pkg::sol_t       sol
);

  localparam int DW    = csl_pkg::DET_W;
  localparam int QW    = csl_pkg::RESULT_WIDTH;
  localparam int FS    = csl_pkg::FRAC_SHIFT;
  localparam int CMP_W = DW + QW - FS;

  // Prep stage 1: magnitudes and sign of the quotient.
  logic          p1_valid, p1_neg, p1_zero;
  logic [DW-1:0] p1_n, p1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= in_valid;
    end
    if (en) begin
      p1_n    <= num[DW-1] ? DW'(-num) : DW'(num);
      p1_d    <= den[DW-1] ? DW'(-den) : DW'(den);
      p1_neg  <= num[DW-1] ^ den[DW-1];
      p1_zero <= (den == '0);
    end
  end

  // Prep stage 2: the quotient overflows QW bits when n >= d * 2^(QW-FS).
  logic [DW+FS-1:0] nsh;
  logic [CMP_W-1:0] lhs, rhs;

  assign nsh = {p1_n, FS'(0)};
  assign lhs = CMP_W'(p1_n);
  assign rhs = CMP_W'(p1_d) << (QW - FS);

  logic          valid [QW+1];
  logic          neg   [QW+1];
  logic          zero  [QW+1];
  logic          ovf   [QW+1];
  logic [DW-1:0] rem   [QW+1];
  logic [DW-1:0] dv    [QW+1];
  logic [QW-1:0] feed  [QW+1];
  logic [QW-1:0] quo   [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= p1_valid;
    end
    if (en) begin
      neg[0]  <= p1_neg;
      zero[0] <= p1_zero;
      ovf[0]  <= lhs >= rhs;
      rem[0]  <= DW'(nsh >> QW);
      feed[0] <= nsh[QW-1:0];
      dv[0]   <= p1_d;
      quo[0]  <= '0;
    end
  end

  // One quotient bit per stage, restoring division.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] r2;
    logic        ge;

    assign r2 = {rem[k], feed[k][QW-1]};
    assign ge = r2 >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        neg[k+1]  <= neg[k];
        zero[k+1] <= zero[k];
        ovf[k+1]  <= ovf[k];
        dv[k+1]   <= dv[k];
        rem[k+1]  <= ge ? DW'(r2 - {1'b0, dv[k]}) : DW'(r2);
        feed[k+1] <= feed[k] << 1;
        quo[k+1]  <= {quo[k][QW-2:0], ge};
      end
    end
  end

  // Output stage: sign and saturation.
  logic [QW-1:0] half;
  logic [QW-1:0] q;
  logic [QW-1:0] sol_next;
  assign half = QW'(1) << (QW - 1);
  assign q    = quo[QW];

  always_comb begin
    if (zero[QW]) begin
      sol_next = '0;
    end else if (!neg[QW]) begin
      sol_next = (ovf[QW] || q > half - QW'(1)) ? half - QW'(1) : q;
    end else begin
      sol_next = (ovf[QW] || q > half) ? half : QW'(-q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid[QW];
    end
    if (en) begin
      sol      <= sol_next;
      out_zero <= zero[QW];
    end
  end

endmodule

>>> rtl/cramer_linear_system_solver.sv
// Cramer's rule solver for two or three linear equations in Q8.8.
//
// Input channel (in_valid / in_ready / in_data): one beat carries a whole
// system, four Q8.8 values per equation. Output channel (out_valid /
// out_ready / out_data): one beat per system with the Q16.16 solutions,
// saturated, and the singular flag; a singular system gives zero solutions.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// unknown count; 2 selects two-unknown mode, any other value three. It is
// always ready and should be written only while the pipeline is empty.
//
// On the path from an accepted input beat to its output beat, three
// stages form the determinants by 2x2 minors, two prepare the magnitudes and
// overflow check, 32 stages each resolve one quotient bit, and one stage
// signs and saturates. A new system is accepted every cycle unless stalled.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets the unknown count to three.
module cramer_linear_system_solver (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  csl_pkg::csl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output csl_pkg::csl_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);

  logic [1:0] unknown_count;

  // The configuration register takes every write at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unknown_count <= csl_pkg::MODE_RESET;
    end else if (cfg_valid) begin
      unknown_count <= cfg_data;
    end
  end

  // All stages move together unless a finished result is stuck at the output.
  logic en;
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  logic               det_valid;
  csl_pkg::csl_dets_t dets;

  csl_det u_det (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .mode_two (unknown_count == csl_pkg::MODE_TWO),
    .in_data  (in_data),
    .out_valid(det_valid),
    .dets     (dets)
  );

  // Three dividers run in lockstep; the x lane also reports a zero determinant.
  logic vx, vy, vz, zx, zy, zz;

  csl_div u_div_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(det_valid),
    .num(dets.dx), .den(dets.d),
    .out_valid(vx), .out_zero(zx), .sol(out_data.sol_x)
  );

  csl_div u_div_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(det_valid),
    .num(dets.dy), .den(dets.d),
    .out_valid(vy), .out_zero(zy), .sol(out_data.sol_y)
  );

  csl_div u_div_z (
    .clk(clk), .rst(rst), .en(en), .in_valid(det_valid),
    .num(dets.dz), .den(dets.d),
    .out_valid(vz), .out_zero(zz), .sol(out_data.sol_z)
  );

  assign out_valid         = vx;
  assign out_data.singular = zx;

  // The three lanes carry the same valid and denominator, so they must agree.
  // The zero flags only carry meaning alongside a valid result.
  assert property (@(posedge clk) disable iff (rst)
    (vx == vy) && (vx == vz) && (!vx || ((zx == zy) && (zx == zz))))
    else $error("divider lanes out of step");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.singular |->
      out_data.sol_x == '0 && out_data.sol_y == '0 && out_data.sol_z == '0)
    else $error("singular system with nonzero solution");

  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
